// ===== hdl/rldu_pkg.sv =====
`default_nettype none
package rldu_pkg;

  localparam int BLOCK_BYTES = 80;
  localparam int HEAD_BYTES  = 8;
  localparam int KEY_BYTES   = 4;
  localparam int TAIL_BYTES  = 16;
  localparam int BODY_END    = HEAD_BYTES + 4 * BLOCK_BYTES;
  localparam int RECORD_LEN  = BODY_END + TAIL_BYTES;

  localparam int POS_W     = $clog2(RECORD_LEN);
  localparam int OUT_POS_W = 9;
  localparam int OFF_W     = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;

  localparam logic [31:0] LC_MUL = 32'h41C6_4E6D;
  localparam logic [31:0] LC_ADD = 32'h0000_6073;

  localparam int SHUF_LSB = 13;
  localparam int SHUF_W   = 5;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 2) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // back-end operations
  localparam logic [2:0] OP_PASS     = 3'd0;  // byte unchanged
  localparam logic [2:0] OP_LOAD     = 3'd1;  // seed <= key, byte unchanged
  localparam logic [2:0] OP_EVEN     = 3'd2;  // step seed, xor bits 23:16
  localparam logic [2:0] OP_EVEN_KEY = 3'd3;  // restart from key, step, xor bits 23:16
  localparam logic [2:0] OP_ODD      = 3'd4;  // xor bits 31:24 of current seed

  typedef struct packed {
    logic [7:0] in_byte;
    logic       record_start;
  } in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic [OUT_POS_W-1:0] out_position;
    logic                 out_last;
  } out_t;

  typedef struct packed {
    logic [2:0]           op;
    logic [7:0]           data;
    logic [OUT_POS_W-1:0] position;
    logic                 last;
    logic [31:0]          key;
  } cmd_t;

  // Block order row for a shuffle value; order[0] in bits 7:6.
  function automatic logic [7:0] order_row(input logic [SHUF_W-1:0] sv);
    logic [SHUF_W-1:0] row;
    logic [7:0]        res;
    row = (sv[4:3] == 2'b11) ? {2'b00, sv[2:0]} : sv;
    case (row)
      5'd0:    res = {2'd0, 2'd1, 2'd2, 2'd3};
      5'd1:    res = {2'd0, 2'd1, 2'd3, 2'd2};
      5'd2:    res = {2'd0, 2'd2, 2'd1, 2'd3};
      5'd3:    res = {2'd0, 2'd3, 2'd1, 2'd2};
      5'd4:    res = {2'd0, 2'd2, 2'd3, 2'd1};
      5'd5:    res = {2'd0, 2'd3, 2'd2, 2'd1};
      5'd6:    res = {2'd1, 2'd0, 2'd2, 2'd3};
      5'd7:    res = {2'd1, 2'd0, 2'd3, 2'd2};
      5'd8:    res = {2'd2, 2'd0, 2'd1, 2'd3};
      5'd9:    res = {2'd3, 2'd0, 2'd1, 2'd2};
      5'd10:   res = {2'd2, 2'd0, 2'd3, 2'd1};
      5'd11:   res = {2'd3, 2'd0, 2'd2, 2'd1};
      5'd12:   res = {2'd1, 2'd2, 2'd0, 2'd3};
      5'd13:   res = {2'd1, 2'd3, 2'd0, 2'd2};
      5'd14:   res = {2'd2, 2'd1, 2'd0, 2'd3};
      5'd15:   res = {2'd3, 2'd1, 2'd0, 2'd2};
      5'd16:   res = {2'd2, 2'd3, 2'd0, 2'd1};
      5'd17:   res = {2'd3, 2'd2, 2'd0, 2'd1};
      5'd18:   res = {2'd1, 2'd2, 2'd3, 2'd0};
      5'd19:   res = {2'd1, 2'd3, 2'd2, 2'd0};
      5'd20:   res = {2'd2, 2'd1, 2'd3, 2'd0};
      5'd21:   res = {2'd3, 2'd1, 2'd2, 2'd0};
      5'd22:   res = {2'd2, 2'd3, 2'd1, 2'd0};
      5'd23:   res = {2'd3, 2'd2, 2'd1, 2'd0};
      default: res = {2'd0, 2'd1, 2'd2, 2'd3};
    endcase
    return res;
  endfunction

  // Slot that receives source block src.
  function automatic logic [1:0] slot_of(input logic [SHUF_W-1:0] sv, input logic [1:0] src);
    logic [7:0] row;
    logic [1:0] slot;
    row  = order_row(sv);
    slot = src;
    for (int j = 3; j >= 0; j--) begin
      if (row[7-2*j -: 2] == src) slot = 2'(j);
    end
    return slot;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/rldu_front.sv =====
`default_nettype none
module rldu_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rldu_pkg::in_t in_data,
  input  wire logic          full,
  output logic               push,
  output rldu_pkg::cmd_t     cmd
);

  logic [rldu_pkg::POS_W-1:0]  pos, pos_next, eff_pos;
  logic [31:0]                 key, key_next;
  logic [rldu_pkg::SHUF_W-1:0] shuf;
  logic [rldu_pkg::OFF_W-1:0]  off;
  logic [1:0]                  src;
  logic                        last, is_body, is_tail, even;
  logic [rldu_pkg::POS_W-1:0]  body_pos;

  function automatic logic [rldu_pkg::POS_W-1:0] slot_mul(input logic [1:0] slot);
    return rldu_pkg::POS_W'(32'(slot) * rldu_pkg::BLOCK_BYTES);
  endfunction

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    eff_pos  = in_data.record_start ? '0 : pos;
    last     = (eff_pos == rldu_pkg::POS_W'(rldu_pkg::RECORD_LEN - 1));
    pos_next = last ? '0 : rldu_pkg::POS_W'(eff_pos + 1'b1);
    is_body  = (eff_pos >= rldu_pkg::POS_W'(rldu_pkg::HEAD_BYTES)) &&
               (eff_pos <  rldu_pkg::POS_W'(rldu_pkg::BODY_END));
    is_tail  = (eff_pos >= rldu_pkg::POS_W'(rldu_pkg::BODY_END));
    // head and body lengths are even, so pair parity follows the position
    even     = !eff_pos[0];

    key_next = key;
    if (eff_pos < rldu_pkg::POS_W'(rldu_pkg::KEY_BYTES)) begin
      case (eff_pos[1:0])
        2'd0:    key_next = {24'd0, in_data.in_byte};
        2'd1:    key_next = key | {16'd0, in_data.in_byte, 8'd0};
        2'd2:    key_next = key | {8'd0, in_data.in_byte, 16'd0};
        2'd3:    key_next = key | {in_data.in_byte, 24'd0};
        default: key_next = key;
      endcase
    end

    body_pos = rldu_pkg::POS_W'(rldu_pkg::HEAD_BYTES)
             + rldu_pkg::POS_W'(slot_mul(rldu_pkg::slot_of(shuf, src)))
             + rldu_pkg::POS_W'(off);

    cmd.data     = in_data.in_byte;
    cmd.last     = last;
    cmd.key      = key_next;
    cmd.position = rldu_pkg::OUT_POS_W'(is_body ? body_pos : eff_pos);
    if (eff_pos == rldu_pkg::POS_W'(rldu_pkg::KEY_BYTES - 1))
      cmd.op = rldu_pkg::OP_LOAD;
    else if (eff_pos == rldu_pkg::POS_W'(rldu_pkg::BODY_END))
      cmd.op = rldu_pkg::OP_EVEN_KEY;
    else if (is_body || is_tail)
      cmd.op = even ? rldu_pkg::OP_EVEN : rldu_pkg::OP_ODD;
    else
      cmd.op = rldu_pkg::OP_PASS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      key  <= '0;
      shuf <= '0;
      off  <= '0;
      src  <= '0;
    end else if (push) begin
      pos <= pos_next;
      key <= key_next;
      if (eff_pos == rldu_pkg::POS_W'(rldu_pkg::KEY_BYTES - 1))
        shuf <= key_next[rldu_pkg::SHUF_LSB +: rldu_pkg::SHUF_W];
      if (eff_pos == rldu_pkg::POS_W'(rldu_pkg::HEAD_BYTES - 1)) begin
        off <= '0;
        src <= '0;
      end else if (is_body) begin
        if (off == rldu_pkg::OFF_W'(rldu_pkg::BLOCK_BYTES - 1)) begin
          off <= '0;
          src <= src + 2'd1;
        end else begin
          off <= off + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rldu_fifo.sv =====
`default_nettype none
module rldu_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rldu_pkg::cmd_t wr_data,
  input  wire logic           pop,
  output rldu_pkg::cmd_t      rd_data,
  output logic                full,
  output logic                empty
);

  rldu_pkg::cmd_t                entry [rldu_pkg::Q_DEPTH];
  logic [rldu_pkg::Q_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [rldu_pkg::Q_CNT_W-1:0]  count;

  assign full    = (count == rldu_pkg::Q_CNT_W'(rldu_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entry[rd_ptr];

  function automatic logic [rldu_pkg::Q_PTR_W-1:0] ptr_inc(
    input logic [rldu_pkg::Q_PTR_W-1:0] p);
    return (p == rldu_pkg::Q_PTR_W'(rldu_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rldu_back.sv =====
`default_nettype none
module rldu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           empty,
  input  wire rldu_pkg::cmd_t cmd,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rldu_pkg::out_t      out_data
);

  logic [31:0] seed, base, step;
  logic [7:0]  val;

  assign pop = !empty && (!out_valid || !out_stall);

  always_comb begin
    base = (cmd.op == rldu_pkg::OP_EVEN_KEY) ? cmd.key : seed;
    step = base * rldu_pkg::LC_MUL + rldu_pkg::LC_ADD;
    case (cmd.op)
      rldu_pkg::OP_EVEN,
      rldu_pkg::OP_EVEN_KEY: val = cmd.data ^ step[23:16];
      rldu_pkg::OP_ODD:      val = cmd.data ^ seed[31:24];
      default:               val = cmd.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      case (cmd.op)
        rldu_pkg::OP_LOAD:     seed <= cmd.key;
        rldu_pkg::OP_EVEN,
        rldu_pkg::OP_EVEN_KEY: seed <= step;
        default:               seed <= seed;
      endcase
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.out_byte     <= val;
      out_data.out_position <= cmd.position;
      out_data.out_last     <= cmd.last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/record_lcrng_decrypt_unshuffle.sv =====
// Record decryptor/unshuffler: takes one encrypted record byte per transfer and returns
// one decrypted byte with its index in the unshuffled record. Sustained rate is one
// byte per cycle on both sides while out_stall is low. Each byte is registered in the
// queue and at the output. The front end tracks the record position, gathers the key
// and maps body bytes to their block slot; a two-entry queue feeds the back end, whose
// single keystream step (one 32-bit constant multiply and add per byte pair) sets the
// rate. record_start restarts a record at any byte; records may follow back to back.
`default_nettype none
module record_lcrng_decrypt_unshuffle (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire rldu_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rldu_pkg::out_t      out_data
);

  rldu_pkg::cmd_t wr_cmd, rd_cmd;
  logic           push, pop, full, empty;

  rldu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .cmd      (wr_cmd)
  );

  rldu_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_cmd),
    .pop     (pop),
    .rd_data (rd_cmd),
    .full    (full),
    .empty   (empty)
  );

  rldu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .cmd       (rd_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== hdl/rldu_checker.sv =====
`default_nettype none
module rldu_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire rldu_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire rldu_pkg::out_t out_data
);

  localparam logic [rldu_pkg::OUT_POS_W-1:0] LAST_POS =
    rldu_pkg::OUT_POS_W'(rldu_pkg::RECORD_LEN - 1);
  localparam logic FITS = (rldu_pkg::RECORD_LEN <= (1 << rldu_pkg::OUT_POS_W));

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input transfer dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transfer dropped or changed while stalled");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && FITS |-> 32'(out_data.out_position) < rldu_pkg::RECORD_LEN)
    else $error("output position beyond record length");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.out_last |-> out_data.out_position == LAST_POS)
    else $error("record end flagged at wrong position");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind record_lcrng_decrypt_unshuffle rldu_checker u_rldu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/tb_record_lcrng_decrypt_unshuffle.sv =====
`default_nettype none
module tb_record_lcrng_decrypt_unshuffle;

  // Block order rows for shuffle values 0-23, two bits per slot, slot 0 in bits 7:6.
  localparam logic [0:23][7:0] ORDER_ROWS = {
    8'h1B, 8'h1E, 8'h27, 8'h36, 8'h2D, 8'h39, 8'h4B, 8'h4E,
    8'h87, 8'hC6, 8'h8D, 8'hC9, 8'h63, 8'h72, 8'h93, 8'hD2,
    8'hB1, 8'hE1, 8'h6C, 8'h78, 8'h9C, 8'hD8, 8'hB4, 8'hE4
  };
  localparam int RANDOM_BYTES = 950;
  localparam int HOLD_CYCLES  = 300;

  class record_scoreboard;
    rldu_pkg::out_t expected_q[$];
    int unsigned    mismatches = 0;
    int unsigned    next_pos   = 0;
    logic [31:0]    key        = '0;
    logic [31:0]    seed       = '0;
    logic [4:0]     shuf       = '0;

    function logic [7:0] keystream(int unsigned rel);
      if (rel % 2 == 0) begin
        seed = seed * rldu_pkg::LC_MUL + rldu_pkg::LC_ADD;
        return seed[23:16];
      end
      return seed[31:24];
    endfunction

    function int unsigned slot_for(int unsigned src);
      logic [7:0]  row;
      int unsigned slot;
      row  = ORDER_ROWS[(shuf >= 24) ? shuf - 24 : shuf];
      slot = src;
      for (int j = 3; j >= 0; j--) begin
        if (row[7-2*j -: 2] == src[1:0]) slot = j;
      end
      return slot;
    endfunction

    function void note_input(rldu_pkg::in_t it);
      int unsigned    p;
      int unsigned    dpos;
      int unsigned    rel;
      logic [7:0]     val;
      rldu_pkg::out_t want;
      p = next_pos;
      if (it.record_start || p >= rldu_pkg::RECORD_LEN) p = 0;
      dpos = p;
      val  = it.in_byte;
      if (p < rldu_pkg::KEY_BYTES) begin
        if (p == 0) key = {24'h0, it.in_byte};
        else key = key | (32'(it.in_byte) << (8 * p));
        if (p == rldu_pkg::KEY_BYTES - 1) begin
          seed = key;
          shuf = key[rldu_pkg::SHUF_LSB +: rldu_pkg::SHUF_W];
        end
      end else if (p >= rldu_pkg::HEAD_BYTES && p < rldu_pkg::BODY_END) begin
        rel  = p - rldu_pkg::HEAD_BYTES;
        val  = it.in_byte ^ keystream(rel);
        dpos = rldu_pkg::HEAD_BYTES
             + slot_for(rel / rldu_pkg::BLOCK_BYTES) * rldu_pkg::BLOCK_BYTES
             + rel % rldu_pkg::BLOCK_BYTES;
      end else if (p >= rldu_pkg::BODY_END) begin
        rel = p - rldu_pkg::BODY_END;
        // tail keystream restarts from the key
        if (rel == 0) seed = key;
        val = it.in_byte ^ keystream(rel);
      end
      want.out_byte     = val;
      want.out_position = rldu_pkg::OUT_POS_W'(dpos);
      want.out_last     = (p == rldu_pkg::RECORD_LEN - 1);
      next_pos = want.out_last ? 0 : p + 1;
      expected_q.push_back(want);
    endfunction

    function void check_result(rldu_pkg::out_t got);
      rldu_pkg::out_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: byte=%h pos=%0d last=%b",
                   got.out_byte, got.out_position, got.out_last);
        return;
      end
      want = expected_q.pop_front();
      if (got.out_byte !== want.out_byte || got.out_position !== want.out_position ||
          got.out_last !== want.out_last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected byte=%h pos=%0d last=%b, got byte=%h pos=%0d last=%b",
                   want.out_byte, want.out_position, want.out_last,
                   got.out_byte, got.out_position, got.out_last);
      end
    endfunction
  endclass

  logic           clk = 1'b0;
  logic           rst;
  logic           in_valid;
  logic           in_stall;
  rldu_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  rldu_pkg::out_t out_data;

  record_scoreboard sb = new();
  bit          quiet      = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned bytes_sent = 0;

  always #4 clk = ~clk;

  record_lcrng_decrypt_unshuffle i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic start);
    int unsigned   gap;
    rldu_pkg::in_t it;
    gap = pick_gap();
    it.in_byte      = b;
    it.record_start = start;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    bytes_sent++;
  endtask

  // rare stray record_start breaks the record in flight
  task automatic send_record(input int unsigned len, input logic start);
    for (int unsigned i = 0; i < len; i++)
      send_byte(8'($urandom_range(0, 255)), (i == 0) ? start : ($urandom_range(0, 299) == 0));
  endtask

  initial begin
    int unsigned base;
    int unsigned kind;
    int unsigned left;
    int unsigned len;
    logic        start;
    bit          prev_full;
    bit          hold_done;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-ones key: shuffle value 31 reuses row 7
    send_byte(8'hFF, 1'b1);
    repeat (3) send_byte(8'hFF, 1'b0);
    repeat (3) begin
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
    end
    // restart in the middle of the body, all-zero key
    send_byte(8'h00, 1'b1);
    repeat (7) send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    // key 0x00030000 gives shuffle value 24
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b0);

    base      = bytes_sent;
    hold_done = 1'b0;
    send_record(rldu_pkg::RECORD_LEN, 1'b1);
    prev_full = 1'b1;
    while (bytes_sent < base + RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 3) == 0);
      if (!hold_done && bytes_sent > base + 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
        quiet     = 1'b1;
      end
      left = base + RANDOM_BYTES - bytes_sent;
      kind = $urandom_range(0, 9);
      // after a full record the next may follow without record_start
      if (kind < 3) begin
        len   = rldu_pkg::RECORD_LEN;
        start = prev_full ? 1'($urandom_range(0, 1)) : 1'b1;
      end else if (kind < 6) begin
        len   = $urandom_range(17, rldu_pkg::RECORD_LEN - 1);
        start = 1'b1;
      end else begin
        len   = $urandom_range(1, 16);
        start = 1'b1;
      end
      if (len > left) len = left;
      send_record(len, start);
      prev_full = (len == rldu_pkg::RECORD_LEN);
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_record_lcrng_decrypt_unshuffle: done, clean");
    end else begin
      $display("tb_record_lcrng_decrypt_unshuffle: done, errors");
    end
    $finish;
  end

  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    int unsigned hold_left;
    bit          stall_now;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (out_valid && !out_stall) sb.check_result(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        stall_now = 1'b1;
      end else if (quiet) begin
        stall_now = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        stall_now = 1'b1;
      end else if (run_left != 0) begin
        run_left--;
        stall_now = 1'b0;
      end else if ($urandom_range(0, 99) < 60) begin
        run_left  = $urandom_range(0, 15);
        stall_now = 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        stall_now  = 1'b1;
      end
      out_stall <= stall_now;
      @(posedge clk);
    end
  end

  initial begin
    #4000000;
    $display("tb_record_lcrng_decrypt_unshuffle: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
